// File: hdl/ipc_pkg.sv
package ipc_pkg;

   // Frame size limits (defaults for the top level parameters)
   localparam int MaxWidthDefault  = 64;
   localparam int MaxHeightDefault = 64;

   // Configuration port
   localparam int CfgW     = 7;
   localparam int CsrAddrW = 2;
   localparam logic [CsrAddrW-1:0] REG_FRAME_HEIGHT = 2'd0;
   localparam logic [CsrAddrW-1:0] REG_FRAME_WIDTH  = 2'd1;

   // Stream payload width (whole bytes)
   localparam int DataW = 8;

   // Result queue depth
   localparam int ResultDepth = 4;

   // One line store entry: the pixel of the row above and its neighbor flag
   typedef struct packed {
      logic covered;
      logic pixel;
   } line_entry_type;

   // Frame verdict handed from the pixel core to the result queue
   typedef struct packed {
      logic valid;
      logic grid_ok;
   } result_type;

   // Index bits for an array of n entries (at least one bit)
   function automatic int idx_bits(input int n);
      int bits;
      bits = (n > 1) ? $clog2(n) : 1;
      return bits;
   endfunction

endpackage

// File: hdl/ipc_line_mem.sv
module ipc_line_mem #(
   parameter int DEPTH = ipc_pkg::MaxWidthDefault,
   parameter int ADDR_W = ipc_pkg::idx_bits(ipc_pkg::MaxWidthDefault)
) (
   input  logic                        clock,
   input  logic [ADDR_W-1:0]           rd_addr,
   output ipc_pkg::line_entry_type     rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  ipc_pkg::line_entry_type     wr_data
);
   import ipc_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   // Write one entry, read one entry with registered data (read-before-write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ipc_result_fifo.sv
module ipc_result_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  ipc_pkg::result_type           push,
   output logic [ipc_pkg::idx_bits(ipc_pkg::ResultDepth + 1)-1:0] count,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_grid_ok
);
   import ipc_pkg::*;

   localparam int PtrW = idx_bits(ResultDepth);
   localparam int CntW = idx_bits(ResultDepth + 1);

   logic            slot_ff [ResultDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign pop         = rsp_tvalid && rsp_tready;
   assign rsp_tvalid  = (count_ff != '0);
   assign rsp_grid_ok = slot_ff[rd_ptr_ff];
   assign count       = count_ff;

   // Advance pointers with wrap, track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(ResultDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(ResultDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the verdict
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.grid_ok;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (count_ff < CntW'(ResultDepth)))
      else $error("result queue overflow");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push.valid |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count did not drop on pop");
`endif

endmodule

// File: hdl/ipc_core.sv
module ipc_core #(
   parameter int MAX_WIDTH  = ipc_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = ipc_pkg::MaxHeightDefault,
   parameter int COL_W      = ipc_pkg::idx_bits(ipc_pkg::MaxWidthDefault)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ipc_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [ipc_pkg::CfgW-1:0]       csr_wdata,
   input  logic                           pix_accept,
   input  logic                           pix_set,
   output logic                           busy,
   output logic [COL_W-1:0]               rd_addr,
   input  ipc_pkg::line_entry_type        rd_data,
   output logic                           wr_en,
   output logic [COL_W-1:0]               wr_addr,
   output ipc_pkg::line_entry_type        wr_data,
   output ipc_pkg::result_type            result
);
   import ipc_pkg::*;

   localparam int RowW = idx_bits(MAX_HEIGHT);

   // Configuration registers
   logic [CfgW-1:0] height_ff;
   logic [CfgW-1:0] width_ff;

   // Position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;

   // Lookup stage signals
   logic [COL_W-1:0] last_col, col;
   logic [RowW-1:0]  last_row_idx, row;
   logic             row_end, last_row;

   // Decide stage registers
   logic             b_valid_ff;
   logic             b_pix_ff;
   logic [COL_W-1:0] b_col_ff;
   logic             b_row_nz_ff;
   logic             b_row_end_ff;
   logic             b_last_row_ff;

   // Row state and frame verdict
   line_entry_type   recent_ff, recent_in;
   logic             iso_ff, iso_in;

   // Row end entry waiting for a free write slot
   logic             pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0] pend_addr_ff, pend_addr_in;
   line_entry_type   pend_data_ff, pend_data_in;

   // Copy of the last memory write, for the read that overlapped it
   logic             fw_en_ff;
   logic [COL_W-1:0] fw_addr_ff;
   line_entry_type   fw_data_ff;

   // Decide stage signals
   line_entry_type   entry, cur;
   logic             col_nz, above, left, cov, found_up, found_left;
   logic             frame_end, iso_now, b_write;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= CfgW'(1);
         width_ff  <= CfgW'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp frame size and position, look up the line entry
   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         last_row_idx = '0;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         last_row_idx = RowW'(MAX_HEIGHT - 1);
      end else begin
         last_row_idx = RowW'(height_ff - 1'b1);
      end
      col      = (col_ff > last_col) ? last_col : col_ff;
      row      = (row_ff > last_row_idx) ? last_row_idx : row_ff;
      row_end  = (col == last_col);
      last_row = (row == last_row_idx);

      if (row_end && last_row) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row + 1'b1;
      end else begin
         col_in = col + 1'b1;
         row_in = row;
      end
   end

   assign rd_addr = col;

   // Advance counters and load the decide stage
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= pix_accept;
         if (pix_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         b_pix_ff      <= pix_set;
         b_col_ff      <= col;
         b_row_nz_ff   <= (row != '0);
         b_row_end_ff  <= row_end;
         b_last_row_ff <= last_row;
      end
   end

   // Decide the pixel above and the pixel to the left
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == b_col_ff)) begin
         entry = pend_data_ff;
      end else if (fw_en_ff && (fw_addr_ff == b_col_ff)) begin
         entry = fw_data_ff;
      end else begin
         entry = rd_data;
      end
      col_nz     = (b_col_ff != '0);
      above      = b_row_nz_ff & entry.pixel;
      found_up   = above & ~entry.covered & ~b_pix_ff;
      left       = col_nz & recent_ff.pixel;
      found_left = left & b_last_row_ff & ~(recent_ff.covered | b_pix_ff);
      cov        = above | left;
      cur.pixel   = b_pix_ff;
      cur.covered = cov;
      frame_end  = b_row_end_ff & b_last_row_ff;
      iso_now    = iso_ff | found_up | found_left | (frame_end & b_pix_ff & ~cov);

      recent_in = recent_ff;
      iso_in    = iso_ff;
      if (b_valid_ff) begin
         recent_in = b_row_end_ff ? '0 : cur;
         iso_in    = frame_end ? 1'b0 : iso_now;
      end
   end

   // Write back the left neighbor, else drain the row end entry
   always_comb begin
      b_write         = b_valid_ff & col_nz;
      wr_en           = b_write | pend_valid_ff;
      wr_addr         = b_write ? b_col_ff - 1'b1 : pend_addr_ff;
      wr_data.pixel   = b_write ? recent_ff.pixel : pend_data_ff.pixel;
      wr_data.covered = b_write ? (recent_ff.covered | b_pix_ff) : pend_data_ff.covered;

      pend_valid_in = pend_valid_ff & b_write;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (b_valid_ff && b_row_end_ff) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = b_col_ff;
         pend_data_in  = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff     <= '0;
         iso_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         fw_en_ff      <= 1'b0;
      end else begin
         recent_ff     <= recent_in;
         iso_ff        <= iso_in;
         pend_valid_ff <= pend_valid_in;
         fw_en_ff      <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      fw_addr_ff   <= wr_addr;
      fw_data_ff   <= wr_data;
   end

   assign busy           = b_valid_ff;
   assign result.valid   = b_valid_ff & frame_end;
   assign result.grid_ok = ~iso_now;

`ifndef ASSERT_OFF
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && col_nz |-> !pend_valid_ff)
      else $error("left write and row end entry compete for the write port");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      pix_accept && row_end && last_row |=> col_ff == '0 && row_ff == '0)
      else $error("position counters did not restart at frame end");
`endif

endmodule

// File: hdl/isolated_pixel_check_top.sv
// Isolated pixel check, 4-connected, over a binary raster frame.
// req_ channel: one pixel per transaction in raster order, req_tdata[0] is
// the pixel. The frame size comes from csr_ registers: index REG_FRAME_HEIGHT
// holds rows, REG_FRAME_WIDTH pixels per row (zero acts as 1, larger than
// the maximum saturates). Write them only while no frame is in progress.
// rsp_ channel: one transaction per frame, after its last pixel;
// rsp_tdata[0] is 1 when no set pixel lacks a set up/down/left/right
// neighbor inside the frame.
// Throughput is one pixel per cycle while req_tready is high: the line store
// is read in the lookup stage and written back in the decide stage, one read
// and one write port. Verdicts pass from the decide stage to the result queue.
// A stalled receiver is absorbed by a four-entry result queue; req_tready
// drops only while that queue and the decide stage could not take another
// verdict. Reset clears counters, queue and registers to a 1x1 frame; the
// line store holds nothing valid and needs no clearing pass.
module isolated_pixel_check_top #(
   parameter int MAX_WIDTH  = ipc_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = ipc_pkg::MaxHeightDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ipc_pkg::DataW-1:0]     req_tdata,   // [0] pixel_set
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ipc_pkg::DataW-1:0]     rsp_tdata,   // [0] grid_ok
   input  logic                          csr_we,
   input  logic [ipc_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [ipc_pkg::CfgW-1:0]      csr_wdata
);
   import ipc_pkg::*;

   localparam int ColW = idx_bits(MAX_WIDTH);
   localparam int CntW = idx_bits(ResultDepth + 1);

   logic             pix_accept;
   logic             busy;
   logic [ColW-1:0]  rd_addr;
   line_entry_type   rd_data;
   logic             wr_en;
   logic [ColW-1:0]  wr_addr;
   line_entry_type   wr_data;
   result_type       result;
   logic [CntW-1:0]  q_count;
   logic             grid_ok;

   // Take a pixel only while the queue has room for every verdict in flight
   assign req_tready = ((CntW+1)'(q_count) + (CntW+1)'(busy)) < (CntW+1)'(ResultDepth);
   assign pix_accept = req_tvalid && req_tready;

   ipc_core #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (ColW)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pix_accept (pix_accept),
      .pix_set    (req_tdata[0]),
      .busy       (busy),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .result     (result)
   );

   ipc_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ColW)
   ) u_line_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ipc_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (result),
      .count       (q_count),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_grid_ok (grid_ok)
   );

   assign rsp_tdata = {(DataW-1)'(0), grid_ok};

endmodule

// File: tb/sv/pixel_verdict_checker.sv
`timescale 1ns / 100ps

// Watch the pixel, result and csr channels, predict each frame verdict and
// compare it with the result transactions in order.
module pixel_verdict_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [ipc_pkg::DataW-1:0]    req_tdata,   // [0] pixel_set
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [ipc_pkg::DataW-1:0]    rsp_tdata,   // [0] grid_ok
   input  logic                         csr_we,
   input  logic [ipc_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [ipc_pkg::CfgW-1:0]     csr_wdata,
   output int                           pending,
   output int                           errors,
   output int                           checked
);
   import ipc_pkg::*;

   // Predictor state: row above, previous pixel, raster position, frame size
   line_entry_type  line_mem [MaxWidthDefault];
   line_entry_type  prev_pixel;
   logic [5:0]      col_pos;
   logic [5:0]      row_pos;
   logic [CfgW-1:0] height_reg;
   logic [CfgW-1:0] width_reg;
   logic            isolated_seen;
   logic            grid_ok_expected [$];
   int              mismatch_cnt;
   int              verdict_cnt;

   // Map a size register onto the frame: zero acts as one, saturate at limit
   function automatic logic [CfgW-1:0] effective_size(input logic [CfgW-1:0] v,
                                                      input int limit);
      if (v == '0)
         return CfgW'(1);
      if (v > limit)
         return CfgW'(limit);
      return v;
   endfunction

   // Advance the raster by one pixel; report a verdict at the frame's end
   task automatic track_isolation(input logic pix, output logic verdict_due,
                                  output logic ok_bit);
      logic [CfgW-1:0] w;
      logic [CfgW-1:0] h;
      logic [CfgW-1:0] c;
      logic [CfgW-1:0] r;
      logic            above;
      logic            left;
      logic            cov;
      logic            found;
      logic            row_end;
      logic            last_row;
      logic            left_cov;
      line_entry_type  ent;
      w = effective_size(width_reg, MaxWidthDefault);
      h = effective_size(height_reg, MaxHeightDefault);
      c = {1'b0, col_pos};
      r = {1'b0, row_pos};
      above = 1'b0;
      left = 1'b0;
      found = 1'b0;
      verdict_due = 1'b0;
      ok_bit = 1'b0;
      if (c >= w)
         c = w - 1'b1;
      if (r >= h)
         r = h - 1'b1;
      row_end = (c == w - 1'b1);
      last_row = (r == h - 1'b1);

      // Decide the pixel above: this was its last chance to gain a neighbor
      if (r != '0) begin
         ent = line_mem[c];
         above = ent.pixel;
         if (ent.pixel && !ent.covered && !pix)
            found = 1'b1;
      end

      // Give the left pixel its right neighbor and store it for the next row
      if (c != '0) begin
         left = prev_pixel.pixel;
         left_cov = prev_pixel.covered | pix;
         line_mem[c - 1'b1] = '{covered: left_cov, pixel: prev_pixel.pixel};
         if (last_row && prev_pixel.pixel && !left_cov)
            found = 1'b1;
      end

      cov = above | left;
      if (row_end) begin
         line_mem[c] = '{covered: cov, pixel: pix};
         prev_pixel = '0;
      end else begin
         prev_pixel = '{covered: cov, pixel: pix};
      end

      if (found)
         isolated_seen = 1'b1;

      if (row_end && last_row) begin
         if (pix && !cov)
            isolated_seen = 1'b1;
         ok_bit = !isolated_seen;
         verdict_due = 1'b1;
         col_pos = '0;
         row_pos = '0;
         prev_pixel = '0;
         isolated_seen = 1'b0;
      end else if (row_end) begin
         col_pos = '0;
         row_pos = r[5:0] + 1'b1;
      end else begin
         col_pos = c[5:0] + 1'b1;
         row_pos = r[5:0];
      end
   endtask

   // Check results first, then predict from the pixel, then apply csr writes
   always @(posedge clock) begin
      logic due;
      logic ok_bit;
      logic want;
      if (reset) begin
         col_pos = '0;
         row_pos = '0;
         prev_pixel = '0;
         isolated_seen = 1'b0;
         height_reg = CfgW'(1);
         width_reg = CfgW'(1);
         grid_ok_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grid_ok_expected.size() == 0) begin
               $display("%0t: unexpected result transaction, expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_cnt++;
            end else begin
               want = grid_ok_expected.pop_front();
               verdict_cnt++;
               if (rsp_tdata !== {{(DataW-1){1'b0}}, want}) begin
                  $display("%0t: grid_ok mismatch, expected %h, actual %h",
                           $time, {{(DataW-1){1'b0}}, want}, rsp_tdata);
                  mismatch_cnt++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            track_isolation(req_tdata[0], due, ok_bit);
            if (due)
               grid_ok_expected.push_back(ok_bit);
         end
         if (csr_we) begin
            case (csr_addr)
               REG_FRAME_HEIGHT: height_reg = csr_wdata;
               REG_FRAME_WIDTH:  width_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pending <= grid_ok_expected.size();
      errors <= mismatch_cnt;
      checked <= verdict_cnt;
   end

endmodule

// File: tb/sv/isolated_pixel_check_top_tb.sv
`timescale 1ns / 100ps

module isolated_pixel_check_top_tb;
   import ipc_pkg::*;

   localparam int ItemTarget  = 1750;
   localparam int StallLimit  = 1000;
   localparam int SettleCycles = 4;
   localparam int DrainCycles = 8;
   localparam int MaxFramePixels = 512;
   localparam logic [CsrAddrW-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CsrAddrW-1:0] REG_SPARE_3 = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DataW-1:0]    req_tdata = '0;   // [0] pixel_set
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DataW-1:0]    rsp_tdata;        // [0] grid_ok
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CfgW-1:0]     csr_wdata = '0;

   int              pending;
   int              errors;
   int              checked;
   int              pixels_sent;
   int              frames_sent;
   int              req_gap_max;
   int              quiet_cycles;
   logic [CfgW-1:0] rows_reg = CfgW'(1);
   logic [CfgW-1:0] cols_reg = CfgW'(1);

   isolated_pixel_check_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pixel_verdict_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors),
      .checked    (checked)
   );

   always #1 clock = ~clock;

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("isolated_pixel_check_top_tb: done, errors");
            $finish;
         end
      end
   end

   // Pick an idle range: none, short or long
   function automatic int pick_gap_max();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 10;
      endcase
   endfunction

   // Rows or columns that a size register value yields
   function automatic int size_in_frame(input logic [CfgW-1:0] v, input int limit);
      if (v == '0)
         return 1;
      if (v > limit)
         return limit;
      return int'(v);
   endfunction

   // Draw a size value: mostly small, sometimes zero, full or oversized
   function automatic logic [CfgW-1:0] draw_size();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return CfgW'(MaxWidthDefault);
         2:       return CfgW'($urandom_range(65, 127));
         default: return CfgW'($urandom_range(1, 8));
      endcase
   endfunction

   // Offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(input logic pix);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(DataW-1){1'b0}}, pix};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // Send a short frame whose pixels are given lowest bit first
   task automatic send_pattern(input logic [15:0] bits, input int n);
      for (int i = 0; i < n; i++)
         send_pixel(bits[i]);
      frames_sent++;
   endtask

   // Send a whole frame at the current size with a given set-pixel density
   task automatic send_random_frame(input int pct);
      int n;
      n = size_in_frame(rows_reg, MaxHeightDefault) * size_in_frame(cols_reg, MaxWidthDefault);
      for (int i = 0; i < n; i++)
         send_pixel($urandom_range(0, 99) < pct);
      frames_sent++;
   endtask

   // Write one register, keeping a copy of the frame size for the stimulus
   task automatic write_csr(input logic [CsrAddrW-1:0] a, input logic [CfgW-1:0] d);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      if (a == REG_FRAME_HEIGHT)
         rows_reg = d;
      else if (a == REG_FRAME_WIDTH)
         cols_reg = d;
      @(posedge clock);
   endtask

   // Drain the block, then write two registers
   task automatic configure(input logic [CsrAddrW-1:0] a0, input logic [CfgW-1:0] d0,
                            input logic [CsrAddrW-1:0] a1, input logic [CfgW-1:0] d1);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SettleCycles) @(posedge clock);
      write_csr(a0, d0);
      write_csr(a1, d1);
      csr_we <= 1'b0;
   endtask

   // Result side: stall a random number of cycles before each transaction
   initial begin
      int stall;
      int stall_max;
      int taken;
      stall_max = 0;
      taken = 0;
      @(posedge clock);
      forever begin
         if (taken % 16 == 0)
            stall_max = pick_gap_max();
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Pixel side: directed frames, then random frames over random sizes
   initial begin
      int              setting;
      int              pct;
      logic [CfgW-1:0] h;
      logic [CfgW-1:0] w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default 1x1 frame after reset: lone set pixel, then clear pixel
      req_gap_max = 0;
      send_pattern(16'b1, 1);
      send_pattern(16'b0, 1);

      // Zero sizes act as a 1x1 frame
      configure(REG_FRAME_HEIGHT, CfgW'(0), REG_FRAME_WIDTH, CfgW'(0));
      send_pattern(16'b1, 1);

      // Single row: isolation decided by the right neighbor or the frame end
      configure(REG_FRAME_HEIGHT, CfgW'(1), REG_FRAME_WIDTH, CfgW'(3));
      req_gap_max = 3;
      send_pattern(16'b010, 3);
      send_pattern(16'b011, 3);
      send_pattern(16'b100, 3);

      // Inner row decided by the pixel below
      configure(REG_FRAME_HEIGHT, CfgW'(2), REG_FRAME_WIDTH, CfgW'(2));
      send_pattern(16'b0001, 4);
      send_pattern(16'b0101, 4);

      // Writes to unused indexes leave the 2x2 frame alone
      configure(REG_SPARE_2, CfgW'(127), REG_SPARE_3, CfgW'(85));
      send_pattern(16'b1010, 4);
      send_pattern(16'b1001, 4);

      // Single column with separated pixels
      configure(REG_FRAME_HEIGHT, CfgW'(3), REG_FRAME_WIDTH, CfgW'(1));
      req_gap_max = 10;
      send_pattern(16'b101, 3);

      // Random sizes, densities and gaps; open with the size extremes
      setting = 0;
      while (pixels_sent < ItemTarget) begin
         case (setting)
            0: begin h = CfgW'(64);  w = CfgW'(2);   end
            1: begin h = CfgW'(2);   w = CfgW'(127); end
            2: begin h = CfgW'(127); w = CfgW'(1);   end
            default: begin h = draw_size(); w = draw_size(); end
         endcase
         if (size_in_frame(h, MaxHeightDefault) * size_in_frame(w, MaxWidthDefault)
             > MaxFramePixels)
            w = CfgW'($urandom_range(1, 8));
         if ($urandom_range(0, 7) == 0)
            configure(REG_SPARE_2, CfgW'($urandom_range(0, 127)),
                      REG_SPARE_3, CfgW'($urandom_range(0, 127)));
         if ($urandom_range(0, 1) == 0)
            configure(REG_FRAME_HEIGHT, h, REG_FRAME_WIDTH, w);
         else
            configure(REG_FRAME_WIDTH, w, REG_FRAME_HEIGHT, h);
         repeat ($urandom_range(1, 3)) begin
            req_gap_max = pick_gap_max();
            case ($urandom_range(0, 4))
               0:       pct = 0;
               1:       pct = 100;
               2:       pct = 12;
               3:       pct = 88;
               default: pct = 50;
            endcase
            send_random_frame(pct);
         end
         setting++;
      end

      // Drain outstanding verdicts and watch a little longer for stray results
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d pixel transactions in %0d frames over %0d size settings,",
               pixels_sent, frames_sent, setting + 5);
      $display("checked %0d verdicts, including zero, full and oversized sizes", checked);
      if (errors == 0 && pending == 0)
         $display("isolated_pixel_check_top_tb: done, clean");
      else
         $display("isolated_pixel_check_top_tb: done, errors");
      $finish;
   end

endmodule

// File: isolated_pixel_check_top.f
hdl/ipc_pkg.sv
hdl/ipc_line_mem.sv
hdl/ipc_result_fifo.sv
hdl/ipc_core.sv
hdl/isolated_pixel_check_top.sv
tb/sv/pixel_verdict_checker.sv
tb/sv/isolated_pixel_check_top_tb.sv
